>>> design/frame_receiver_checksum_check_assert.svh
// Assertion macros for the frame receiver with checksum check.
// Used by frc_front, frc_queue and frc_back; expects clk and arst_n in scope.
`ifndef FRAME_RECEIVER_CHECKSUM_CHECK_ASSERT_SVH
`define FRAME_RECEIVER_CHECKSUM_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define FRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds
`define FRC_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define FRC_ASSERT(label, prop, msg)
`define FRC_NEVER(label, cond, msg)
`endif
`endif

>>> design/frc_pkg.sv
// Shared types, codes and helpers of the frame receiver with checksum check.
// No dependencies.
package frc_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h53;
	localparam logic [7:0] HDR_SECOND = 8'h4E;
	localparam logic [7:0] HDR_THIRD  = 8'h55;
	localparam logic [7:0] END_BYTE   = 8'h0A;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified item handed from the front to the back
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        short_frame;
		logic [15:0] rx_ck;
	} op_t;

	// Ones'-complement add with end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

>>> design/frc_front.sv
// Front part: header hunt, tail delay line and classification of items.
// Depends on frc_pkg and the assertion macro header.
`include "frame_receiver_checksum_check_assert.svh"
module frc_front
	import frc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push,
	output op_t        push_op
);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_N     = 2'd1;
	localparam logic [1:0] PH_U     = 2'd2;
	localparam logic [1:0] PH_FRAME = 2'd3;

	logic [1:0] phase_q;
	logic [7:0] tail_q [3];
	logic [1:0] fill_q;
	logic       acc;
	logic       in_frame;
	logic       is_end;
	logic       tail_full;

	assign rx_stall  = q_full;
	assign acc       = rx_valid && !rx_stall;
	assign in_frame  = (phase_q == PH_FRAME);
	assign is_end    = (rx_byte == END_BYTE);
	assign tail_full = (fill_q == 2'd3);

	// Emit an op for a newline or for a byte that pushes one out of the tail
	assign push = acc && in_frame && (is_end || tail_full);

	always_comb begin
		push_op             = '0;
		push_op.short_frame = !tail_full;
		push_op.rx_ck       = {tail_q[1], tail_q[0]};
		if (is_end) begin
			push_op.kind = KIND_STATUS;
		end else begin
			push_op.kind = KIND_PAYLOAD;
			push_op.data = tail_q[0];
		end
	end

	// Advance header hunt and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fill_q  <= 2'd0;
		end else if (acc) begin
			case (phase_q)
				PH_HUNT: phase_q <= (rx_byte == HDR_FIRST) ? PH_N : PH_HUNT;
				PH_N:    phase_q <= (rx_byte == HDR_SECOND) ? PH_U : PH_HUNT;
				PH_U: begin
					phase_q <= (rx_byte == HDR_THIRD) ? PH_FRAME : PH_HUNT;
					fill_q  <= 2'd0;
				end
				PH_FRAME: begin
					if (is_end) begin
						phase_q <= PH_HUNT;
						fill_q  <= 2'd0;
					end else if (!tail_full) begin
						fill_q <= fill_q + 2'd1;
					end
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// Fill or shift the tail delay line
	always_ff @(posedge clk) begin
		if (acc && in_frame && !is_end) begin
			if (tail_full) begin
				tail_q[0] <= tail_q[1];
				tail_q[1] <= tail_q[2];
				tail_q[2] <= rx_byte;
			end else begin
				tail_q[fill_q] <= rx_byte;
			end
		end
	end

	`FRC_ASSERT(a_end_hunts, (acc && in_frame && is_end) |=> (phase_q == PH_HUNT && fill_q == 2'd0), "newline did not return to hunting")
	`FRC_NEVER(a_push_outside_frame, push && !in_frame, "op pushed outside a frame")
	`FRC_ASSERT(a_fill_hold_hunt, (phase_q == PH_HUNT) |-> (fill_q == 2'd0), "tail fill not clear while hunting")

endmodule

>>> design/frc_queue.sv
// Short queue of classified items between front and back.
// Depends on frc_pkg and the assertion macro header.
`include "frame_receiver_checksum_check_assert.svh"
module frc_queue
	import frc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	output logic q_valid,
	input  logic pop,
	output op_t  q_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_op    = slot_q[rd_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	`FRC_NEVER(a_push_full, push && full, "push into a full queue")
	`FRC_NEVER(a_pop_empty, pop && !q_valid, "pop from an empty queue")
	`FRC_NEVER(a_count_range, count_q > CW'(DEPTH), "queue count out of range")

endmodule

>>> design/frc_back.sv
// Back part: ones'-complement sum, checksum compare and output register.
// Depends on frc_pkg and the assertion macro header.
`include "frame_receiver_checksum_check_assert.svh"
module frc_back
	import frc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  op_t        q_op,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic [1:0] frame_status
);

	logic [15:0] sum_q;
	logic        odd_q;
	logic [7:0]  pend_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  data_q;
	logic [1:0]  status_q;
	logic [15:0] final_sum;
	logic [1:0]  status_nxt;

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_byte     = data_q;
	assign frame_status = status_q;

	// Take an item when the output register is free or being emptied
	assign pop = q_valid && (!out_valid_q || !out_stall);

	// Fold in a waiting odd byte and compare the complement, unless the frame is short
	always_comb begin
		final_sum = odd_q ? ones_add(sum_q, {8'd0, pend_q}) : sum_q;
		if (q_op.short_frame) begin
			status_nxt = ST_SHORT;
		end else if (~final_sum == q_op.rx_ck) begin
			status_nxt = ST_OK;
		end else begin
			status_nxt = ST_MISMATCH;
		end
	end

	// Update the running sum and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			odd_q       <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_PAYLOAD;
			data_q      <= '0;
			status_q    <= ST_OK;
		end else if (pop) begin
			out_valid_q <= 1'b1;
			kind_q      <= q_op.kind;
			if (q_op.kind == KIND_STATUS) begin
				data_q   <= '0;
				status_q <= status_nxt;
				sum_q    <= '0;
				odd_q    <= 1'b0;
				pend_q   <= '0;
			end else begin
				data_q   <= q_op.data;
				status_q <= ST_OK;
				if (odd_q) begin
					sum_q  <= ones_add(sum_q, {q_op.data, pend_q});
					odd_q  <= 1'b0;
					pend_q <= '0;
				end else begin
					pend_q <= q_op.data;
					odd_q  <= 1'b1;
				end
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	`FRC_ASSERT(a_clear_after_status, (pop && q_op.kind == KIND_STATUS) |=> (sum_q == 16'd0 && !odd_q), "sum not cleared at end of frame")
	`FRC_ASSERT(a_payload_status_zero, (out_valid_q && kind_q == KIND_PAYLOAD) |-> (status_q == ST_OK), "payload item with nonzero status")
	`FRC_ASSERT(a_status_byte_zero, (out_valid_q && kind_q == KIND_STATUS) |-> (data_q == 8'd0), "status item with nonzero byte")

endmodule

>>> design/frame_receiver_checksum_check.sv
// Frame receiver with ones'-complement checksum check. Received bytes are
// taken at one byte per cycle while the queue is not full; the front hunts the
// S,N,U header and keeps the last three frame bytes, the back streams payload
// out three bytes late and sums it as little-endian 16-bit words. A byte taken
// is classified into the queue and passes on to the output register when the
// back can take it, so a newline's status item (ok, mismatch, or frame too
// short) is offered once it has passed the queue and the output register.
// The input stalls only while the queue between front and back is full.
// Top level; depends on frc_pkg, frc_front, frc_queue and frc_back.
module frame_receiver_checksum_check
	import frc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] out_byte,
	output logic [1:0] frame_status
);

	logic push;
	op_t  push_op;
	logic q_full;
	logic q_valid;
	logic pop;
	op_t  q_op;

	frc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	frc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.q_valid (q_valid),
		.pop     (pop),
		.q_op    (q_op)
	);

	frc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_op         (q_op),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.out_byte     (out_byte),
		.frame_status (frame_status)
	);

endmodule
